### rtl/ogrid_pkg.sv
// -----------------------------------------------------------------------------
// ogrid_pkg
// Shared types, codes and defaults for the occupancy grid engine.
// -----------------------------------------------------------------------------
package ogrid_pkg;

   localparam int DEF_MAX_COLUMNS = 64;
   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_ODDS_WIDTH  = 8;

   localparam int COORD_W    = 16;
   localparam int EDGE_W     = 15;
   localparam int RECIP_W    = 16;
   localparam int SIZE_W     = 7;
   localparam int THRESH_W   = 8;
   localparam int OUT_ODDS_W = 8;
   localparam int OUT_IDX_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Q0.16 reciprocal rounding: half of one unit of the 16-bit fraction of the product
   localparam int ROUND_HALF = 32768;
   localparam int FRAC_SHIFT = 16;

   typedef enum logic [1:0] {
      OP_MARK    = 2'd0,
      OP_QUERY   = 2'd1,
      OP_NEAREST = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CLS_CLEAR     = 2'd0,
      CLS_UNCERTAIN = 2'd1,
      CLS_OBSTACLE  = 2'd2
   } class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Y   = 3'd1,
      REG_CELL_EDGE  = 3'd2,
      REG_EDGE_RECIP = 3'd3,
      REG_COLUMNS    = 3'd4,
      REG_ROWS       = 3'd5,
      REG_OCC_THRESH = 3'd6,
      REG_FREE_THRESH = 3'd7
   } csr_reg_type;

endpackage

### rtl/ogrid_mul.sv
// -----------------------------------------------------------------------------
// ogrid_mul
// Shared signed multiplier with a registered product.
// -----------------------------------------------------------------------------
module ogrid_mul #(
   parameter int WIDTH = 25
) (
   input  logic                      clock,
   input  logic signed [WIDTH-1:0]   operand_a,
   input  logic signed [WIDTH-1:0]   operand_b,
   output logic signed [2*WIDTH-1:0] product
);

   logic signed [2*WIDTH-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= operand_a * operand_b;
   end

   assign product = product_ff;

endmodule

### rtl/occupancy_grid_engine_top.sv
// -----------------------------------------------------------------------------
// occupancy_grid_engine_top
// Occupancy grid with saturating odds per cell: mark, query and nearest
// obstacle search, all sequenced over one shared multiplier and one cell RAM.
// -----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | operation, point_x, point_y
//  rsp     | out       | rsp_valid/rsp_stall | class, odds, indices, flags, center
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  Mark and query run two multiplier passes, one RAM read, one update and the
//  output load before rsp_valid rises; a point off the grid skips the RAM read
//  and the update. Nearest scans every cell of the configured grid in turn:
//  each cell takes a RAM read and a class check, and an obstacle cell also
//  takes dx and dy squared in turn on the shared multiplier and a compare.
//  After reset a clearing pass writes all MAX_COLUMNS*MAX_ROWS RAM entries
//  with req_stall high. A result held by rsp_stall does not block the next
//  request transfer; the engine waits only to hand off its next one.
// -----------------------------------------------------------------------------
module occupancy_grid_engine_top #(
   parameter int MAX_COLUMNS = ogrid_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = ogrid_pkg::DEF_MAX_ROWS,
   parameter int ODDS_WIDTH  = ogrid_pkg::DEF_ODDS_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_operation,
   input  logic signed [ogrid_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [ogrid_pkg::COORD_W-1:0]   req_point_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_cell_class,
   output logic signed [ogrid_pkg::OUT_ODDS_W-1:0] rsp_cell_odds,
   output logic [ogrid_pkg::OUT_IDX_W-1:0]        rsp_column_index,
   output logic [ogrid_pkg::OUT_IDX_W-1:0]        rsp_row_index,
   output logic                                   rsp_out_of_range,
   output logic                                   rsp_found,
   output logic signed [ogrid_pkg::COORD_W-1:0]   rsp_center_x,
   output logic signed [ogrid_pkg::COORD_W-1:0]   rsp_center_y,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ogrid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ogrid_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import ogrid_pkg::*;

   localparam int DEPTH   = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COL_W   = $clog2(MAX_COLUMNS);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int CCNT_W  = ($clog2(MAX_COLUMNS + 1) > SIZE_W) ? $clog2(MAX_COLUMNS + 1) : SIZE_W;
   localparam int RCNT_W  = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
   localparam int TERM_W  = $clog2(2 * MAX_DIM + 1) + EDGE_W;
   localparam int MUL_W   = ((TERM_W > 18) ? TERM_W : 18) + 2;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int MAG_W   = PROD_W - FRAC_SHIFT;
   localparam int DIST_W  = PROD_W;
   localparam int MEM_W   = ODDS_WIDTH + 2;
   localparam int CMP_W   = ((ODDS_WIDTH > THRESH_W) ? ODDS_WIDTH : THRESH_W) + 1;

   typedef enum logic [12:0] {
      S_CLEAR  = 13'b0000000000001,
      S_IDLE   = 13'b0000000000010,
      S_IX     = 13'b0000000000100,
      S_IY     = 13'b0000000001000,
      S_ADDR   = 13'b0000000010000,
      S_READ   = 13'b0000000100000,
      S_UPD    = 13'b0000001000000,
      S_NSTART = 13'b0000010000000,
      S_NREAD  = 13'b0000100000000,
      S_NCHK   = 13'b0001000000000,
      S_NDY    = 13'b0010000000000,
      S_NCMP   = 13'b0100000000000,
      S_FIN    = 13'b1000000000000
   } state_type;

   // nearest search finishes through S_NCMP/S_NCHK, or S_NSTART on an empty grid, into S_FIN
   state_type state_ff, state_in;

   // configuration
   logic signed [COORD_W-1:0]  origin_x_ff, origin_y_ff;
   logic [EDGE_W-1:0]          cell_edge_ff;
   logic [RECIP_W-1:0]         recip_ff;
   logic [SIZE_W-1:0]          columns_ff, rows_ff;
   logic signed [THRESH_W-1:0] occ_thresh_ff, free_thresh_ff;

   // cell RAM
   logic [MEM_W-1:0] mem [DEPTH];
   logic [MEM_W-1:0] rd_ff;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [MEM_W-1:0] wr_data;

   // sequencer datapath
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic                      nearest_ff, nearest_in;
   logic                      mark_ff, mark_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [MUL_W-1:0]   offx_ff, offx_in, offy_ff, offy_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      col_bad_ff, col_bad_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in, rowbase_ff, rowbase_in;
   logic [TERM_W-1:0]         colterm_ff, colterm_in, rowterm_ff, rowterm_in;
   logic [DIST_W-1:0]         sq_ff, sq_in, best_ff, best_in;
   logic                      have_ff, have_in;
   logic [COL_W-1:0]          best_col_ff, best_col_in;
   logic [ROW_W-1:0]          best_row_ff, best_row_in;
   logic [TERM_W-1:0]         best_cterm_ff, best_cterm_in, best_rterm_ff, best_rterm_in;
   logic [OUT_ODDS_W-1:0]     best_odds_ff, best_odds_in;

   // staged result and output register
   logic [1:0]             res_class_ff, res_class_in;
   logic [OUT_ODDS_W-1:0]  res_odds_ff, res_odds_in;
   logic [OUT_IDX_W-1:0]   res_col_ff, res_col_in, res_row_ff, res_row_in;
   logic                   res_oor_ff, res_oor_in, res_found_ff, res_found_in;
   logic [COORD_W-1:0]     res_cx_ff, res_cx_in, res_cy_ff, res_cy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             out_class_ff;
   logic [OUT_ODDS_W-1:0]  out_odds_ff;
   logic [OUT_IDX_W-1:0]   out_col_ff, out_row_ff;
   logic                   out_oor_ff, out_found_ff;
   logic [COORD_W-1:0]     out_cx_ff, out_cy_ff;
   logic                   out_load;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] product;

   ogrid_mul #(.WIDTH(MUL_W)) u_mul (
      .clock     (clock),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product)
   );

   // helpers
   logic [CCNT_W-1:0]          cols_eff;
   logic [RCNT_W-1:0]          rows_eff;
   logic [PROD_W-1:0]          prod_abs;
   logic [PROD_W-1:0]          prod_rnd;
   logic [MAG_W-1:0]           idx_mag;
   logic                       idx_neg;
   logic                       col_bad_now, row_bad_now;
   logic [1:0]                 rd_class;
   logic signed [ODDS_WIDTH-1:0] rd_odds, odds_new;
   logic signed [CMP_W-1:0]    odds_c, occ_c, free_c;
   logic [1:0]                 class_new;
   logic signed [MUL_W-1:0]    dx, dy;
   logic [DIST_W-1:0]          dist_sum;
   logic                       last_col, last_row, advance;
   logic                       accept;

   assign cols_eff = (CCNT_W'(columns_ff) > CCNT_W'(MAX_COLUMNS)) ?
                     CCNT_W'(MAX_COLUMNS) : CCNT_W'(columns_ff);
   assign rows_eff = (RCNT_W'(rows_ff) > RCNT_W'(MAX_ROWS)) ?
                     RCNT_W'(MAX_ROWS) : RCNT_W'(rows_ff);

   // round half away from zero on the magnitude
   assign prod_abs    = product[PROD_W-1] ? PROD_W'(-product) : PROD_W'(product);
   assign prod_rnd    = prod_abs + PROD_W'(ROUND_HALF);
   assign idx_mag     = prod_rnd[PROD_W-1:FRAC_SHIFT];
   assign idx_neg     = product[PROD_W-1] && (idx_mag != '0);
   assign col_bad_now = idx_neg || (idx_mag >= MAG_W'(cols_eff));
   assign row_bad_now = idx_neg || (idx_mag >= MAG_W'(rows_eff));

   assign rd_class = rd_ff[MEM_W-1:ODDS_WIDTH];
   assign rd_odds  = rd_ff[ODDS_WIDTH-1:0];
   assign odds_new = (rd_odds == {1'b0, {(ODDS_WIDTH-1){1'b1}}}) ? rd_odds : rd_odds + 1'b1;
   assign odds_c   = CMP_W'(odds_new);
   assign occ_c    = CMP_W'(occ_thresh_ff);
   assign free_c   = CMP_W'(free_thresh_ff);
   assign class_new = (odds_c >= occ_c) ? CLS_OBSTACLE :
                      (odds_c <= free_c) ? CLS_CLEAR : CLS_UNCERTAIN;

   assign dx       = $signed(MUL_W'(colterm_ff)) + offx_ff;
   assign dy       = $signed(MUL_W'(rowterm_ff)) + offy_ff;
   assign dist_sum = sq_ff + DIST_W'(product);

   assign last_col = (CCNT_W'(col_ff) + 1'b1) == cols_eff;
   assign last_row = (RCNT_W'(row_ff) + 1'b1) == rows_eff;

   assign accept   = req_valid && !req_stall;
   assign out_load = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      nearest_in    = nearest_ff;
      mark_in       = mark_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      offx_in       = offx_ff;
      offy_in       = offy_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      col_bad_in    = col_bad_ff;
      addr_in       = addr_ff;
      rowbase_in    = rowbase_ff;
      colterm_in    = colterm_ff;
      rowterm_in    = rowterm_ff;
      sq_in         = sq_ff;
      best_in       = best_ff;
      have_in       = have_ff;
      best_col_in   = best_col_ff;
      best_row_in   = best_row_ff;
      best_cterm_in = best_cterm_ff;
      best_rterm_in = best_rterm_ff;
      best_odds_in  = best_odds_ff;
      res_class_in  = res_class_ff;
      res_odds_in   = res_odds_ff;
      res_col_in    = res_col_ff;
      res_row_in    = res_row_ff;
      res_oor_in    = res_oor_ff;
      res_found_in  = res_found_ff;
      res_cx_in     = res_cx_ff;
      res_cy_in     = res_cy_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = rd_ff;
      mul_a         = dx;
      mul_b         = dx;
      advance       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = {CLS_CLEAR, ODDS_WIDTH'(0)};
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               px_in      = req_point_x;
               py_in      = req_point_y;
               nearest_in = (req_operation == OP_NEAREST);
               mark_in    = (req_operation == OP_MARK);
               offx_in    = (MUL_W'(origin_x_ff) - MUL_W'(req_point_x)) <<< 1;
               offy_in    = (MUL_W'(origin_y_ff) - MUL_W'(req_point_y)) <<< 1;
               state_in   = (req_operation == OP_NEAREST) ? S_NSTART : S_IX;
            end
         end
         S_IX: begin
            mul_a    = MUL_W'(px_ff) - MUL_W'(origin_x_ff);
            mul_b    = $signed(MUL_W'(recip_ff));
            state_in = S_IY;
         end
         S_IY: begin
            mul_a      = MUL_W'(py_ff) - MUL_W'(origin_y_ff);
            mul_b      = $signed(MUL_W'(recip_ff));
            col_in     = COL_W'(idx_mag);
            col_bad_in = col_bad_now;
            state_in   = S_ADDR;
         end
         S_ADDR: begin
            row_in  = ROW_W'(idx_mag);
            addr_in = ADDR_W'(ADDR_W'(ROW_W'(idx_mag)) * ADDR_W'(MAX_COLUMNS)) +
                      ADDR_W'(col_ff);
            if (col_bad_ff || row_bad_now) begin
               res_class_in = CLS_OBSTACLE;
               res_odds_in  = '0;
               res_col_in   = '0;
               res_row_in   = '0;
               res_oor_in   = 1'b1;
               res_found_in = 1'b0;
               res_cx_in    = '0;
               res_cy_in    = '0;
               state_in     = S_FIN;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            res_col_in   = OUT_IDX_W'(col_ff);
            res_row_in   = OUT_IDX_W'(row_ff);
            res_oor_in   = 1'b0;
            res_found_in = 1'b0;
            res_cx_in    = '0;
            res_cy_in    = '0;
            if (mark_ff) begin
               wr_en        = 1'b1;
               wr_data      = {class_new, odds_new};
               res_class_in = class_new;
               res_odds_in  = OUT_ODDS_W'(odds_new);
            end else begin
               res_class_in = rd_class;
               res_odds_in  = OUT_ODDS_W'(rd_odds);
            end
            state_in = S_FIN;
         end
         S_NSTART: begin
            col_in     = '0;
            row_in     = '0;
            addr_in    = '0;
            rowbase_in = '0;
            colterm_in = TERM_W'(cell_edge_ff);
            rowterm_in = TERM_W'(cell_edge_ff);
            have_in    = 1'b0;
            if (cols_eff == '0 || rows_eff == '0) begin
               advance = 1'b0;
               state_in = S_NCMP;
               // empty grid: stage a not-found result here and go straight to S_FIN
               res_class_in = '0;
               res_odds_in  = '0;
               res_col_in   = '0;
               res_row_in   = '0;
               res_oor_in   = 1'b0;
               res_found_in = 1'b0;
               res_cx_in    = '0;
               res_cy_in    = '0;
               state_in     = S_FIN;
            end else begin
               state_in = S_NREAD;
            end
         end
         S_NREAD: begin
            state_in = S_NCHK;
         end
         S_NCHK: begin
            if (rd_class == CLS_OBSTACLE) begin
               mul_a    = dx;
               mul_b    = dx;
               state_in = S_NDY;
            end else begin
               advance = 1'b1;
            end
         end
         S_NDY: begin
            mul_a    = dy;
            mul_b    = dy;
            sq_in    = DIST_W'(product);
            state_in = S_NCMP;
         end
         S_NCMP: begin
            if (!have_ff || dist_sum < best_ff) begin
               have_in       = 1'b1;
               best_in       = dist_sum;
               best_col_in   = col_ff;
               best_row_in   = row_ff;
               best_cterm_in = colterm_ff;
               best_rterm_in = rowterm_ff;
               best_odds_in  = OUT_ODDS_W'(rd_odds);
            end
            advance = 1'b1;
         end
         S_FIN: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (last_col) begin
            col_in     = '0;
            colterm_in = TERM_W'(cell_edge_ff);
            row_in     = row_ff + 1'b1;
            rowterm_in = rowterm_ff + TERM_W'({cell_edge_ff, 1'b0});
            rowbase_in = rowbase_ff + ADDR_W'(MAX_COLUMNS);
            addr_in    = rowbase_ff + ADDR_W'(MAX_COLUMNS);
         end else begin
            col_in     = col_ff + 1'b1;
            colterm_in = colterm_ff + TERM_W'({cell_edge_ff, 1'b0});
            addr_in    = addr_ff + 1'b1;
         end
         if (last_col && last_row) begin
            // winner uses this cycle's update when the last cell is the best
            if (have_in) begin
               res_class_in = CLS_OBSTACLE;
               res_odds_in  = best_odds_in;
               res_col_in   = OUT_IDX_W'(best_col_in);
               res_row_in   = OUT_IDX_W'(best_row_in);
               res_found_in = 1'b1;
               res_cx_in    = COORD_W'(best_cterm_in >> 1) + origin_x_ff;
               res_cy_in    = COORD_W'(best_rterm_in >> 1) + origin_y_ff;
            end else begin
               res_class_in = '0;
               res_odds_in  = '0;
               res_col_in   = '0;
               res_row_in   = '0;
               res_found_in = 1'b0;
               res_cx_in    = '0;
               res_cy_in    = '0;
            end
            res_oor_in = 1'b0;
            state_in   = S_FIN;
         end else begin
            state_in = S_NREAD;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // cell RAM: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         cell_edge_ff   <= EDGE_W'(256);
         recip_ff       <= RECIP_W'(256);
         columns_ff     <= SIZE_W'(64);
         rows_ff        <= SIZE_W'(64);
         occ_thresh_ff  <= THRESH_W'(3);
         free_thresh_ff <= -THRESH_W'(3);
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               REG_ORIGIN_X:    origin_x_ff    <= csr_wdata;
               REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata;
               REG_CELL_EDGE:   cell_edge_ff   <= csr_wdata[EDGE_W-1:0];
               REG_EDGE_RECIP:  recip_ff       <= csr_wdata;
               REG_COLUMNS:     columns_ff     <= csr_wdata[SIZE_W-1:0];
               REG_ROWS:        rows_ff        <= csr_wdata[SIZE_W-1:0];
               REG_OCC_THRESH:  occ_thresh_ff  <= csr_wdata[THRESH_W-1:0];
               REG_FREE_THRESH: free_thresh_ff <= csr_wdata[THRESH_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      nearest_ff    <= nearest_in;
      mark_ff       <= mark_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      offx_ff       <= offx_in;
      offy_ff       <= offy_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      col_bad_ff    <= col_bad_in;
      addr_ff       <= addr_in;
      rowbase_ff    <= rowbase_in;
      colterm_ff    <= colterm_in;
      rowterm_ff    <= rowterm_in;
      sq_ff         <= sq_in;
      best_ff       <= best_in;
      have_ff       <= have_in;
      best_col_ff   <= best_col_in;
      best_row_ff   <= best_row_in;
      best_cterm_ff <= best_cterm_in;
      best_rterm_ff <= best_rterm_in;
      best_odds_ff  <= best_odds_in;
      res_class_ff  <= res_class_in;
      res_odds_ff   <= res_odds_in;
      res_col_ff    <= res_col_in;
      res_row_ff    <= res_row_in;
      res_oor_ff    <= res_oor_in;
      res_found_ff  <= res_found_in;
      res_cx_ff     <= res_cx_in;
      res_cy_ff     <= res_cy_in;
      if (out_load) begin
         out_class_ff <= res_class_ff;
         out_odds_ff  <= res_odds_ff;
         out_col_ff   <= res_col_ff;
         out_row_ff   <= res_row_ff;
         out_oor_ff   <= res_oor_ff;
         out_found_ff <= res_found_ff;
         out_cx_ff    <= res_cx_ff;
         out_cy_ff    <= res_cy_ff;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_class   = out_class_ff;
   assign rsp_cell_odds    = out_odds_ff;
   assign rsp_column_index = out_col_ff;
   assign rsp_row_index    = out_row_ff;
   assign rsp_out_of_range = out_oor_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_center_x     = out_cx_ff;
   assign rsp_center_y     = out_cy_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while engine busy");

   a_found_is_obstacle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_cell_class == CLS_OBSTACLE && !rsp_out_of_range))
      else $error("found result without obstacle class");

   a_oor_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
      (rsp_cell_class == CLS_OBSTACLE && rsp_column_index == '0 && rsp_row_index == '0))
      else $error("out of range result fields wrong");

   a_nearest_no_write: assert property (@(posedge clock) disable iff (reset)
      (nearest_ff && state_ff != S_CLEAR && state_ff != S_IDLE) |-> !wr_en)
      else $error("RAM write during nearest search");
`endif

endmodule

### tb/occupancy_grid_engine_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// occupancy_grid_engine_top_tb
// Drives mark, query and nearest-obstacle requests through a series of grid
// setups, predicts every response from a local copy of the grid, and checks
// the responses in order while requests idle and responses stall at random.
// -----------------------------------------------------------------------------
module occupancy_grid_engine_top_tb;
   import ogrid_pkg::*;

   localparam int GRID_COLS = DEF_MAX_COLUMNS;
   localparam int GRID_ROWS = DEF_MAX_ROWS;
   localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 32;

   typedef struct packed {
      logic [1:0]         cls;
      logic signed [7:0]  odds;
      logic [5:0]         col;
      logic [5:0]         row;
      logic               oor;
      logic               found;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
   } grid_rsp_type;

   class grid_scoreboard;
      logic signed [7:0] odds_mem[GRID_CELLS];
      class_type         cls_mem[GRID_CELLS];
      logic signed [15:0] org_x, org_y, recip_u;
      logic [14:0]        edge_len;
      logic [6:0]         cols, rows;
      logic signed [7:0]  occ_th, free_th;
      grid_rsp_type       pending[$];
      int                 errors;

      function new();
         foreach (odds_mem[i]) begin
            odds_mem[i] = '0;
            cls_mem[i] = CLS_CLEAR;
         end
         org_x = 0; org_y = 0; edge_len = 256; recip_u = 256;
         cols = 64; rows = 64; occ_th = 3; free_th = -3;
         errors = 0;
      endfunction

      function void set_reg(csr_reg_type idx, logic [15:0] val);
         case (idx)
            REG_ORIGIN_X:    org_x = val;
            REG_ORIGIN_Y:    org_y = val;
            REG_CELL_EDGE:   edge_len = val[14:0];
            REG_EDGE_RECIP:  recip_u = val;
            REG_COLUMNS:     cols = val[6:0];
            REG_ROWS:        rows = val[6:0];
            REG_OCC_THRESH:  occ_th = val[7:0];
            REG_FREE_THRESH: free_th = val[7:0];
            default: ;
         endcase
      endfunction

      function longint eff_cols();
         return (cols > GRID_COLS) ? GRID_COLS : longint'(cols);
      endfunction

      function longint eff_rows();
         return (rows > GRID_ROWS) ? GRID_ROWS : longint'(rows);
      endfunction

      // round-half-away mapping of a coordinate onto a cell index
      function longint cell_of(longint p, longint o);
         longint prod;
         prod = (p - o) * longint'($unsigned(recip_u));
         if (prod >= 0) return (prod + ROUND_HALF) >>> FRAC_SHIFT;
         return -(((-prod) + ROUND_HALF) >>> FRAC_SHIFT);
      endfunction

      function void note_request(logic [1:0] op, logic signed [15:0] x,
                                 logic signed [15:0] y);
         grid_rsp_type r;
         longint px, py, ox, oy, e, c, rw, a, dx, dy, d, best, bc, br;
         bit have;
         r = '0;
         px = x; py = y; ox = org_x; oy = org_y; e = edge_len;
         have = 0; best = 0; bc = 0; br = 0;
         if (op == OP_NEAREST) begin
            for (longint ri = 0; ri < eff_rows(); ri++)
               for (longint ci = 0; ci < eff_cols(); ci++) begin
                  a = ri * GRID_COLS + ci;
                  if (cls_mem[a] != CLS_OBSTACLE) continue;
                  dx = (2 * ci + 1) * e + 2 * ox - 2 * px;
                  dy = (2 * ri + 1) * e + 2 * oy - 2 * py;
                  d = dx * dx + dy * dy;
                  if (!have || d < best) begin
                     have = 1; best = d; bc = ci; br = ri;
                  end
               end
            if (have) begin
               a = br * GRID_COLS + bc;
               r.cls = CLS_OBSTACLE;
               r.odds = odds_mem[a];
               r.col = bc[5:0];
               r.row = br[5:0];
               r.found = 1'b1;
               d = (((2 * bc + 1) * e) >>> 1) + ox;
               r.cx = d[15:0];
               d = (((2 * br + 1) * e) >>> 1) + oy;
               r.cy = d[15:0];
            end
         end else begin
            c = cell_of(px, ox);
            rw = cell_of(py, oy);
            if (c < 0 || c >= eff_cols() || rw < 0 || rw >= eff_rows()) begin
               r.cls = CLS_OBSTACLE;
               r.oor = 1'b1;
            end else begin
               a = rw * GRID_COLS + c;
               if (op == OP_MARK) begin
                  if (odds_mem[a] != 8'sd127) odds_mem[a] = odds_mem[a] + 8'sd1;
                  if (odds_mem[a] >= occ_th) cls_mem[a] = CLS_OBSTACLE;
                  else if (odds_mem[a] <= free_th) cls_mem[a] = CLS_CLEAR;
                  else cls_mem[a] = CLS_UNCERTAIN;
               end
               r.cls = cls_mem[a];
               r.odds = odds_mem[a];
               r.col = c[5:0];
               r.row = rw[5:0];
            end
         end
         pending = {pending, r};
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_result(grid_rsp_type got);
         grid_rsp_type w;
         if (pending.size() == 0) begin
            report("unexpected response", 1, 0);
            return;
         end
         w = pending.pop_front();
         if (got.cls !== w.cls) report("cell_class", got.cls, w.cls);
         if (got.odds !== w.odds) report("cell_odds", got.odds, w.odds);
         if (got.col !== w.col) report("column_index", got.col, w.col);
         if (got.row !== w.row) report("row_index", got.row, w.row);
         if (got.oor !== w.oor) report("out_of_range", got.oor, w.oor);
         if (got.found !== w.found) report("found", got.found, w.found);
         if (got.cx !== w.cx) report("center_x", got.cx, w.cx);
         if (got.cy !== w.cy) report("center_y", got.cy, w.cy);
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_operation;
   logic signed [15:0] req_point_x, req_point_y;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_cell_class;
   logic signed [7:0] rsp_cell_odds;
   logic [5:0] rsp_column_index, rsp_row_index;
   logic rsp_out_of_range, rsp_found;
   logic signed [15:0] rsp_center_x, rsp_center_y;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;

   grid_scoreboard grid_sb;
   int unsigned cycle_count;
   int unsigned nearest_pct;
   bit hold_request;

   occupancy_grid_engine_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cell_class(rsp_cell_class),
      .rsp_cell_odds(rsp_cell_odds), .rsp_column_index(rsp_column_index),
      .rsp_row_index(rsp_row_index), .rsp_out_of_range(rsp_out_of_range),
      .rsp_found(rsp_found), .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin : rsp_stall_gen
      int hold_left;
      int burst;
      hold_left = 0;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b0;
            burst--;
         end else begin
            case ($urandom_range(0, 19))
               0:       burst = $urandom_range(20, 80);
               1:       hold_left = $urandom_range(10, 40);
               2, 3, 4: rsp_stall <= 1'b1;
               default: rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      grid_rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.cls = rsp_cell_class; got.odds = rsp_cell_odds;
         got.col = rsp_column_index; got.row = rsp_row_index;
         got.oor = rsp_out_of_range; got.found = rsp_found;
         got.cx = rsp_center_x; got.cy = rsp_center_y;
         grid_sb.check_result(got);
      end
   end

   task automatic write_reg(csr_reg_type idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      grid_sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // the sender goes quiet before waiting, so no request is offered twice
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (grid_sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_grid_setup(logic [15:0] ox, logic [15:0] oy, logic [15:0] edge_len,
                                  logic [15:0] recip, logic [15:0] cols, logic [15:0] rows,
                                  logic [15:0] occ, logic [15:0] free_lvl);
      drain_results();
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_CELL_EDGE, edge_len);
      write_reg(REG_EDGE_RECIP, recip);
      write_reg(REG_COLUMNS, cols);
      write_reg(REG_ROWS, rows);
      write_reg(REG_OCC_THRESH, occ);
      write_reg(REG_FREE_THRESH, free_lvl);
   endtask

   task automatic send_request(logic [1:0] op, logic [15:0] x, logic [15:0] y);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (req_stall);
      grid_sb.note_request(op, x, y);
      case ($urandom_range(0, 9))
         0, 1, 2:    gap = $urandom_range(1, 3);
         3:          gap = $urandom_range(10, 40);
         default:    gap = 0;
      endcase
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // coordinate that lands near cell i along one axis, occasionally off-grid
   function automatic logic [15:0] coord_for(longint o, longint recip, longint span);
      longint i, p;
      if (recip == 0 || span == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
      i = $urandom_range(0, span - 1);
      p = o + (i * 65536 + longint'($urandom_range(0, 60000)) - 30000) / recip;
      return p[15:0];
   endfunction

   task automatic random_requests(int count);
      logic [1:0] op;
      int unsigned pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < nearest_pct) op = OP_NEAREST;
         else if (pick < 55) op = OP_MARK;
         else if (pick < 92) op = OP_QUERY;
         else op = 2'd3;
         send_request(op,
            coord_for(grid_sb.org_x, $unsigned(grid_sb.recip_u), grid_sb.eff_cols()),
            coord_for(grid_sb.org_y, $unsigned(grid_sb.recip_u), grid_sb.eff_rows()));
      end
   endtask

   initial begin
      grid_sb = new();
      cycle_count = 0;
      hold_request = 1'b0;
      nearest_pct = 12;
      reset = 1'b1;
      req_valid = 1'b0; req_operation = OP_MARK; req_point_x = '0; req_point_y = '0;
      csr_valid = 1'b0; csr_index = REG_ORIGIN_X; csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset setup, one cell per 256 units
      send_request(OP_NEAREST, 16'sd0, 16'sd0);           // empty grid
      send_request(OP_QUERY, 16'sd0, 16'sd0);
      repeat (3) send_request(OP_MARK, 16'sd256, 16'sd512);
      send_request(OP_NEAREST, 16'sd0, 16'sd0);
      send_request(OP_NEAREST, 16'sd32767, 16'sd32767);
      send_request(OP_QUERY, -16'sd32768, -16'sd32768);
      send_request(OP_QUERY, 16'sd32767, 16'sd32767);
      send_request(2'd3, 16'sd256, 16'sd512);             // unused code acts as query
      send_request(OP_MARK, 16'sd16128, 16'sd16128);      // far corner
      send_request(OP_MARK, -16'sd128, 16'sd0);           // rounds to -1
      send_request(OP_MARK, 16'sd127, 16'sd0);
      send_request(OP_MARK, 16'sd128, 16'sd0);            // half rounds up
      repeat (3) send_request(OP_MARK, 16'sd0, 16'sd0);
      repeat (3) send_request(OP_MARK, 16'sd512, 16'sd0);
      send_request(OP_NEAREST, 16'sd384, 16'sd128);       // tie, first scanned wins
      send_request(OP_NEAREST, -16'sd32768, 16'sd32767);
      // sender pause until all responses are back
      drain_results();
      send_request(OP_QUERY, 16'sd512, 16'sd0);

      // long receiver hold-off while requests keep coming
      load_grid_setup(16'h0000, 16'h0000, 16'd256, 16'd256, 16'd8, 16'd8, 16'd2, 16'hFFFE);
      hold_request = 1'b1;
      random_requests(200);

      load_grid_setup(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd1, 16'd1, 16'h7F, 16'h80);
      random_requests(120);
      load_grid_setup(16'hFE00, 16'hFE00, 16'd128, 16'd512, 16'd6, 16'd4, 16'd1, 16'hFFFF);
      random_requests(200);
      load_grid_setup(16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'h80, 16'h7F);
      random_requests(60);
      load_grid_setup(16'h0000, 16'h0000, 16'd0, 16'd256, 16'd5, 16'd3, 16'h80, 16'h7F);
      random_requests(80);
      // oversize grid saturates at full size; nearest is slow here
      nearest_pct = 2;
      load_grid_setup(16'd100, 16'hFF38, 16'd300, 16'd218, 16'd127, 16'd127, 16'd4, 16'hFFFC);
      random_requests(200);
      nearest_pct = 12;
      for (int ph = 0; ph < 6; ph++) begin
         load_grid_setup(16'($urandom), 16'($urandom), 16'($urandom_range(1, 32767)),
                         16'($urandom_range(1, 65535)), 16'($urandom_range(1, 8)),
                         16'($urandom_range(1, 8)),
                         ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 5)) :
                                                       16'($urandom),
                         16'($urandom));
         random_requests(140);
      end

      drain_results();
      if (grid_sb.pending.size() != 0)
         grid_sb.report("responses left over", grid_sb.pending.size(), 0);
      if (grid_sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
